[src/sset_pkg.sv]
// Shared types and constants for the sorted set algebra engine.
package sset_pkg;

    localparam int SET_CAPACITY = 16;
    localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
    localparam int VAL_W        = 32;
    localparam int IN_USER_W    = 4;
    localparam int OUT_DATA_W   = 40;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_UNION  = 3'd2,
        OP_INTER  = 3'd3,
        OP_DIFF   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2
    } t_ins_status;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_ROTATE,
        CMD_CLEAR
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd               cmd;
        logic signed [VAL_W-1:0] value;
    } t_chain_ctl;

    typedef struct packed {
        logic signed [VAL_W-1:0] head;
        logic                    dup;
        logic                    full;
        logic [CNT_W-1:0]        cnt;
    } t_chain_sts;

endpackage

[src/sset_cell.sv]
// One cell of a sorted shift chain: holds one entry and its valid bit.
module sset_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sset_pkg::t_cell_cmd                 i_cmd,
    input  logic signed [sset_pkg::VAL_W-1:0]   i_value,
    input  logic signed [sset_pkg::VAL_W-1:0]   i_prev_val,
    input  logic                                i_prev_valid,
    input  logic                                i_prev_gt,
    input  logic signed [sset_pkg::VAL_W-1:0]   i_next_val,
    input  logic                                i_next_valid,
    output logic signed [sset_pkg::VAL_W-1:0]   o_val,
    output logic                                o_valid,
    output logic                                o_gt,
    output logic                                o_eq
);

    logic signed [sset_pkg::VAL_W-1:0] r_val;
    logic signed [sset_pkg::VAL_W-1:0] n_val;
    logic                              r_valid;
    logic                              n_valid;

    assign o_gt    = r_valid && (r_val < i_value);
    assign o_eq    = r_valid && (r_val == i_value);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        unique case (i_cmd)
            sset_pkg::CMD_INSERT: begin
                // Entries below the new value stay; the slot right after them
                // takes the value and everything above moves up one cell.
                if (!o_gt) begin
                    if (i_prev_gt) begin
                        n_val   = i_value;
                        n_valid = 1'b1;
                    end else begin
                        n_val   = i_prev_val;
                        n_valid = i_prev_valid;
                    end
                end
            end
            sset_pkg::CMD_ROTATE: begin
                n_val   = i_next_val;
                n_valid = i_next_valid;
            end
            sset_pkg::CMD_CLEAR: begin
                n_valid = 1'b0;
            end
            sset_pkg::CMD_HOLD: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[src/sset_chain.sv]
// Sorted shift chain holding one set, with its entry count.
module sset_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sset_pkg::t_chain_ctl i_ctl,
    output sset_pkg::t_chain_sts o_sts
);

    logic signed [sset_pkg::VAL_W-1:0] w_val   [sset_pkg::SET_CAPACITY];
    logic                              w_valid [sset_pkg::SET_CAPACITY];
    logic [sset_pkg::SET_CAPACITY-1:0] w_gt;
    logic [sset_pkg::SET_CAPACITY-1:0] w_eq;
    logic [sset_pkg::CNT_W-1:0]        r_cnt;
    logic [sset_pkg::CNT_W-1:0]        n_cnt;

    for (genvar g = 0; g < sset_pkg::SET_CAPACITY; g++) begin : g_cell
        logic signed [sset_pkg::VAL_W-1:0] prev_val;
        logic                              prev_valid;
        logic                              prev_gt;

        if (g == 0) begin : g_head
            // The head acts as if an entry below every value stood before it.
            assign prev_val   = '0;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b1;
        end else begin : g_body
            assign prev_val   = w_val[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_gt    = w_gt[g-1];
        end

        sset_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_ctl.cmd),
            .i_value      (i_ctl.value),
            .i_prev_val   (prev_val),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_val   (w_val[(g + 1) % sset_pkg::SET_CAPACITY]),
            .i_next_valid (w_valid[(g + 1) % sset_pkg::SET_CAPACITY]),
            .o_val        (w_val[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g]),
            .o_eq         (w_eq[g])
        );
    end

    always_comb begin
        n_cnt = r_cnt;
        unique case (i_ctl.cmd)
            sset_pkg::CMD_INSERT: n_cnt = r_cnt + sset_pkg::CNT_W'(1);
            sset_pkg::CMD_CLEAR:  n_cnt = '0;
            sset_pkg::CMD_HOLD,
            sset_pkg::CMD_ROTATE: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_sts.head = w_val[0];
    assign o_sts.dup  = |w_eq;
    assign o_sts.full = (r_cnt == sset_pkg::CAP_CNT);
    assign o_sts.cnt  = r_cnt;

endmodule

[src/sorted_set_algebra_engine_top.sv]
// Top level of the sorted set algebra engine: two set chains and the merge sequencer.
//
//   channel  direction  handshake                     payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   tdata value, tuser operation+target set
//   m_axis   out        m_axis_tvalid/m_axis_tready   tdata value/found/status, tuser, tlast
//
// Insert, search and clear need no sequencing; the chain compares all cells at once.
// A union, intersection or difference runs its merge steps (at most count A + count B),
// then a merge step that sees both sets used up, then the flush state for the final word,
// and then rotates both chains back to their home position. No input is taken meanwhile.
// Merge steps wait while the output register holds an untaken word.
// Reset is synchronous and active low; it empties both sets at once.
module sorted_set_algebra_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [3:0]  s_axis_tuser,   // [2:0] operation, [3] target_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [32] found, [34:33] status
    output logic        m_axis_tuser,   // [0] has_value
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_FLUSH,
        S_RESTORE
    } t_state;

    t_state                            r_state, n_state;
    sset_pkg::t_op                     r_mode, n_mode;
    logic [sset_pkg::CNT_W-1:0]        r_rot_a, n_rot_a;
    logic [sset_pkg::CNT_W-1:0]        r_rot_b, n_rot_b;
    logic signed [sset_pkg::VAL_W-1:0] r_pend, n_pend;
    logic                              r_pend_v, n_pend_v;
    logic                              r_ov, n_ov;
    logic [sset_pkg::OUT_DATA_W-1:0]   r_odata, n_odata;
    logic                              r_ouser, n_ouser;
    logic                              r_olast, n_olast;

    sset_pkg::t_chain_ctl ctl_a, ctl_b;
    sset_pkg::t_chain_sts sts_a, sts_b;

    sset_pkg::t_op                     in_op;
    logic                              in_sel;
    logic signed [sset_pkg::VAL_W-1:0] in_val;
    logic                              can_push;
    logic                              tgt_dup;
    logic                              tgt_full;
    logic                              ex_a, ex_b;
    logic                              take_a, take_b;
    logic                              emit;
    logic signed [sset_pkg::VAL_W-1:0] emit_val;

    assign in_op    = sset_pkg::t_op'(s_axis_tuser[2:0]);
    assign in_sel   = s_axis_tuser[3];
    assign in_val   = $signed(s_axis_tdata);
    assign can_push = !r_ov || m_axis_tready;
    assign tgt_dup  = in_sel ? sts_b.dup  : sts_a.dup;
    assign tgt_full = in_sel ? sts_b.full : sts_a.full;

    // Chains are popped by rotating; a set is used up once all its entries went by.
    assign ex_a     = (r_rot_a == sts_a.cnt);
    assign ex_b     = (r_rot_b == sts_b.cnt);
    assign take_a   = !ex_a && (ex_b || (sts_a.head < sts_b.head));
    assign take_b   = !ex_b && (ex_a || (sts_b.head < sts_a.head));
    assign emit_val = take_b ? sts_b.head : sts_a.head;

    always_comb begin
        unique case (r_mode)
            sset_pkg::OP_UNION: emit = 1'b1;
            sset_pkg::OP_INTER: emit = !take_a && !take_b;
            sset_pkg::OP_DIFF:  emit = take_a;
            default:            emit = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && can_push;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_rot_a  = r_rot_a;
        n_rot_b  = r_rot_b;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_ov     = r_ov && !m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        ctl_a    = '{cmd: sset_pkg::CMD_HOLD, value: in_val};
        ctl_b    = '{cmd: sset_pkg::CMD_HOLD, value: in_val};

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && can_push) begin
                    unique case (in_op)
                        sset_pkg::OP_INSERT: begin
                            n_ov    = 1'b1;
                            n_odata = '0;
                            n_ouser = 1'b0;
                            n_olast = 1'b1;
                            if (tgt_dup) begin
                                n_odata[34:33] = sset_pkg::ST_DUP;
                            end else if (tgt_full) begin
                                n_odata[34:33] = sset_pkg::ST_FULL;
                            end else begin
                                n_odata[34:33] = sset_pkg::ST_ADDED;
                                if (in_sel) begin
                                    ctl_b.cmd = sset_pkg::CMD_INSERT;
                                end else begin
                                    ctl_a.cmd = sset_pkg::CMD_INSERT;
                                end
                            end
                        end
                        sset_pkg::OP_SEARCH: begin
                            n_ov        = 1'b1;
                            n_odata     = '0;
                            n_odata[32] = tgt_dup;
                            n_ouser     = 1'b0;
                            n_olast     = 1'b1;
                        end
                        sset_pkg::OP_UNION,
                        sset_pkg::OP_INTER,
                        sset_pkg::OP_DIFF: begin
                            n_mode   = in_op;
                            n_state  = S_MERGE;
                            n_rot_a  = '0;
                            n_rot_b  = '0;
                            n_pend_v = 1'b0;
                        end
                        sset_pkg::OP_CLEAR: begin
                            n_ov    = 1'b1;
                            n_odata = '0;
                            n_ouser = 1'b0;
                            n_olast = 1'b1;
                            if (in_sel) begin
                                ctl_b.cmd = sset_pkg::CMD_CLEAR;
                            end else begin
                                ctl_a.cmd = sset_pkg::CMD_CLEAR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MERGE: begin
                if (ex_a && ex_b) begin
                    n_state = S_FLUSH;
                end else if (can_push) begin
                    if (!take_b) begin
                        ctl_a.cmd = sset_pkg::CMD_ROTATE;
                        n_rot_a   = r_rot_a + sset_pkg::CNT_W'(1);
                    end
                    if (!take_a) begin
                        ctl_b.cmd = sset_pkg::CMD_ROTATE;
                        n_rot_b   = r_rot_b + sset_pkg::CNT_W'(1);
                    end
                    // One element is held back so the final one can carry tlast.
                    if (emit) begin
                        if (r_pend_v) begin
                            n_ov    = 1'b1;
                            n_odata = {8'b0, r_pend};
                            n_ouser = 1'b1;
                            n_olast = 1'b0;
                        end
                        n_pend   = emit_val;
                        n_pend_v = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (can_push) begin
                    n_ov    = 1'b1;
                    n_odata = r_pend_v ? {8'b0, r_pend} : '0;
                    n_ouser = r_pend_v;
                    n_olast = 1'b1;
                    n_state = S_RESTORE;
                end
            end
            S_RESTORE: begin
                if (r_rot_a != sset_pkg::CAP_CNT) begin
                    ctl_a.cmd = sset_pkg::CMD_ROTATE;
                    n_rot_a   = r_rot_a + sset_pkg::CNT_W'(1);
                end
                if (r_rot_b != sset_pkg::CAP_CNT) begin
                    ctl_b.cmd = sset_pkg::CMD_ROTATE;
                    n_rot_b   = r_rot_b + sset_pkg::CNT_W'(1);
                end
                if (r_rot_a == sset_pkg::CAP_CNT && r_rot_b == sset_pkg::CAP_CNT) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pend  <= n_pend;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= sset_pkg::OP_UNION;
            r_rot_a  <= '0;
            r_rot_b  <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_rot_a  <= n_rot_a;
            r_rot_b  <= n_rot_b;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    sset_chain u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .o_sts   (sts_a)
    );

    sset_chain u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .o_sts   (sts_b)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_rot_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot_a <= sset_pkg::CAP_CNT)
        else $error("set A rotation count beyond capacity");

    a_merge_a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_rot_a <= sts_a.cnt && r_rot_b <= sts_b.cnt))
        else $error("merge popped more entries than a set holds");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts_a.cnt <= sset_pkg::CAP_CNT && sts_b.cnt <= sset_pkg::CAP_CNT)
        else $error("set count beyond capacity");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && can_push) |=> (r_ov && r_olast && r_state == S_RESTORE))
        else $error("final merge word not marked last");

endmodule
